@@ hw/rtl/deque_state_scan_update_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the state code deque.
// Define NO_ASSERTIONS to compile every check away.
// ---------------------------------------------------------------------------
`ifndef DEQUE_STATE_SCAN_UPDATE_MACROS_SVH
`define DEQUE_STATE_SCAN_UPDATE_MACROS_SVH
`ifndef NO_ASSERTIONS
// The condition must hold at every edge outside reset.
`define DSSU_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("deque check failed");
// The consequent must hold in the cycle after the antecedent.
`define DSSU_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("deque sequencing check failed");
`else
`define DSSU_ASSERT_ALWAYS(lbl, cond)
`define DSSU_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ hw/rtl/dssu_pkg.sv @@
// ---------------------------------------------------------------------------
// dssu_pkg
// Shared types and codes of the state code deque.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dssu_pkg;

	// Actions carried by an input word.
	typedef enum logic [2:0] {
		ACT_PUSH_BACK   = 3'd0,
		ACT_PUSH_FRONT  = 3'd1,
		ACT_POP_BACK    = 3'd2,
		ACT_POP_FRONT   = 3'd3,
		ACT_COUNT       = 3'd4,
		ACT_PAIR_COUNT  = 3'd5,
		ACT_UPDATE      = 3'd6,
		ACT_PAIR_UPDATE = 3'd7
	} action_t;

	// Status codes returned with every result word.
	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_EMPTY   = 2'd1,
		STAT_FULL    = 2'd2,
		STAT_MISSING = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_PUSH,
		S_POP_RD,
		S_POP_WT,
		S_SCAN,
		S_WR1,
		S_WR2,
		S_FIN_F,
		S_FIN_B,
		S_FIN_W,
		S_DONE
	} state_t;

	// Control of the shared compare and count unit.
	typedef struct packed {
		logic clear;
		logic valid;
		logic pair_mode;
		logic rewrite;
	} match_ctl_t;

endpackage

@@ hw/rtl/dssu_if.sv @@
// ---------------------------------------------------------------------------
// dssu_in_if / dssu_out_if
// Valid/ready channels for action words and result words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dssu_in_if #(
	parameter int CODE_BITS = 4,
	parameter int IDX_BITS  = 10
);
	logic                 valid;
	logic                 ready;
	logic [2:0]           action;
	logic [CODE_BITS-1:0] match_first;
	logic [CODE_BITS-1:0] match_second;
	logic [CODE_BITS-1:0] write_first;
	logic [CODE_BITS-1:0] write_second;
	logic [IDX_BITS-1:0]  instance_req;

	modport source (output valid, action, match_first, match_second, write_first,
		write_second, instance_req, input ready);
	modport sink (input valid, action, match_first, match_second, write_first,
		write_second, instance_req, output ready);
endinterface

interface dssu_out_if #(
	parameter int CODE_BITS = 4,
	parameter int CNT_BITS  = 11
);
	logic                 valid;
	logic                 ready;
	logic [CODE_BITS-1:0] popped_code;
	logic [CNT_BITS-1:0]  match_count;
	logic [CNT_BITS-1:0]  fill_level;
	logic [CODE_BITS-1:0] front_code;
	logic [CODE_BITS-1:0] back_code;
	logic [1:0]           status;

	modport source (output valid, popped_code, match_count, fill_level, front_code,
		back_code, status, input ready);
	modport sink (input valid, popped_code, match_count, fill_level, front_code,
		back_code, status, output ready);
endinterface

@@ hw/rtl/dssu_store.sv @@
// ---------------------------------------------------------------------------
// dssu_store
// Circular entry store: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dssu_store #(
	parameter int DEPTH     = 1024,
	parameter int CODE_BITS = 4,
	localparam int AW       = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [CODE_BITS-1:0] wdata,
	input  logic [AW-1:0]        raddr,
	output logic [CODE_BITS-1:0] rdata_q
);

	logic [CODE_BITS-1:0] mem_q [DEPTH];

	// Write first in program order; the read returns the old word on a collision.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

@@ hw/rtl/dssu_match.sv @@
// ---------------------------------------------------------------------------
// dssu_match
// Shared compare and count unit, fed one stored code per cycle in queue order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dssu_match #(
	parameter int DEPTH     = 1024,
	parameter int CODE_BITS = 4,
	localparam int AW       = $clog2(DEPTH),
	localparam int CW       = AW + 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dssu_pkg::match_ctl_t ctl,
	input  logic [CODE_BITS-1:0] code,
	input  logic [CODE_BITS-1:0] first,
	input  logic [CODE_BITS-1:0] second,
	input  logic [AW-1:0]        target,
	output logic [CW-1:0]        match_count,
	output logic                 hit
);
	import dssu_pkg::*;

	logic [CW-1:0]        count_q;
	logic [CODE_BITS-1:0] prev_q;
	logic                 prev_avail_q;
	logic                 single_m;
	logic                 pair_m;
	logic                 m;

	// A pair needs the previous entry still unclaimed by an earlier pair.
	always_comb begin
		single_m = (code == first);
		pair_m   = prev_avail_q && (prev_q == first) && (code == second);
		m        = ctl.pair_mode ? pair_m : single_m;
		hit      = ctl.valid && m && ctl.rewrite && (count_q == {1'b0, target});
	end

	assign match_count = count_q;

	// After a pair matches, both entries are consumed; the next pair needs two new entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			prev_avail_q <= 1'b0;
		end else if (ctl.clear) begin
			count_q      <= '0;
			prev_avail_q <= 1'b0;
		end else if (ctl.valid) begin
			count_q      <= count_q + {{(CW-1){1'b0}}, m};
			prev_avail_q <= !(ctl.pair_mode && m);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.valid) begin
			prev_q <= code;
		end
	end

endmodule

@@ hw/rtl/deque_state_scan_update.sv @@
// ---------------------------------------------------------------------------
// deque_state_scan_update
// Double-ended queue of state codes with scan-based count and rewrite.
// ---------------------------------------------------------------------------
// Usage: the item channel takes one action word (push or pop at either end,
// count a code, count non-overlapping pairs, rewrite the nth code match or
// the nth pair). The result channel returns exactly one word per action with
// the popped code, the match count, the fill level, both end codes and a
// status code.
// Path from acceptance to a valid result: a push passes S_PUSH, a pop
// S_POP_RD and S_POP_WT, a push on full or a pop on empty neither. A count
// or pair count walks the store through its single read port, one entry per
// cycle into the shared compare unit. A rewrite stops the walk at its match
// and adds the write state S_WR1, followed by S_WR2 for a pair. Every action
// then reads both end codes in S_FIN_F, S_FIN_B and S_FIN_W. One word is in
// flight at a time; ready is high only while the block is idle, which it
// becomes once each result word is delivered.
// Reset empties the queue at once; the store itself is not cleared.
// When the receiver stalls, the result word holds in its register and no
// new action word is taken until it has been delivered.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "deque_state_scan_update_macros.svh"

module deque_state_scan_update #(
	parameter int DEPTH     = 1024,
	parameter int CODE_BITS = 4
) (
	input logic       clk,
	input logic       arst_n,
	dssu_in_if.sink   item,
	dssu_out_if.source result
);
	import dssu_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;
	localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);
	localparam logic [AW-1:0] LAST    = AW'(DEPTH - 1);

	// Store index of a queue position, modulo DEPTH.
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] fp,
		input logic [AW-1:0] pos);
		logic [AW:0] sum;
		sum = {1'b0, fp} + {1'b0, pos};
		if (sum >= DEPTH_W) begin
			sum = sum - DEPTH_W;
		end
		return sum[AW-1:0];
	endfunction

	state_t               state_q;
	state_t               state_d;
	action_t              act_q;
	logic [CODE_BITS-1:0] mf_q;
	logic [CODE_BITS-1:0] ms_q;
	logic [CODE_BITS-1:0] wf_q;
	logic [CODE_BITS-1:0] ws_q;
	logic [AW-1:0]        inst_q;
	logic [CW-1:0]        count_q;
	logic [AW-1:0]        fp_q;
	logic [CW-1:0]        rd_pos_q;
	logic                 rd_vld_s1;
	logic [AW-1:0]        data_pos_s1;
	logic [AW-1:0]        hit_pos_q;
	logic [CODE_BITS-1:0] popped_q;
	logic [CODE_BITS-1:0] front_q;
	logic [CODE_BITS-1:0] back_q;
	status_t              status_q;

	logic                 accept;
	logic                 full;
	logic                 empty;
	logic                 is_pair;
	logic                 is_rewrite;
	logic                 is_front;
	logic [AW-1:0]        fp_dec;
	logic [AW-1:0]        fp_inc;
	logic [AW-1:0]        last_pos;
	logic                 issue;
	logic                 scan_done;
	logic                 hit;
	logic [CW-1:0]        mcount;
	match_ctl_t           mctl;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic [CODE_BITS-1:0] wdata;
	logic [AW-1:0]        raddr;
	logic [CODE_BITS-1:0] rdata;

	// Decode of the held action and the pointer arithmetic.
	always_comb begin
		accept     = item.valid && item.ready;
		full       = (count_q >= DEPTH_W);
		empty      = (count_q == '0);
		is_pair    = (act_q == ACT_PAIR_COUNT) || (act_q == ACT_PAIR_UPDATE);
		is_rewrite = (act_q == ACT_UPDATE) || (act_q == ACT_PAIR_UPDATE);
		is_front   = (act_q == ACT_PUSH_FRONT) || (act_q == ACT_POP_FRONT);
		fp_dec     = (fp_q == '0) ? LAST : fp_q - 1'b1;
		fp_inc     = (fp_q == LAST) ? '0 : fp_q + 1'b1;
		last_pos   = empty ? '0 : AW'(count_q - 1'b1);
		issue      = (state_q == S_SCAN) && (rd_pos_q < count_q) && !hit;
		scan_done  = !rd_vld_s1 && (rd_pos_q == count_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item.valid) begin
					unique case (action_t'(item.action))
						ACT_PUSH_BACK, ACT_PUSH_FRONT: state_d = full ? S_FIN_F : S_PUSH;
						ACT_POP_BACK, ACT_POP_FRONT:   state_d = empty ? S_FIN_F : S_POP_RD;
						default:                       state_d = S_SCAN;
					endcase
				end
			end
			S_PUSH:   state_d = S_FIN_F;
			S_POP_RD: state_d = S_POP_WT;
			S_POP_WT: state_d = S_FIN_F;
			S_SCAN: begin
				if (hit) begin
					state_d = S_WR1;
				end else if (scan_done) begin
					state_d = S_FIN_F;
				end
			end
			S_WR1:    state_d = is_pair ? S_WR2 : S_FIN_F;
			S_WR2:    state_d = S_FIN_F;
			S_FIN_F:  state_d = S_FIN_B;
			S_FIN_B:  state_d = S_FIN_W;
			S_FIN_W:  state_d = S_DONE;
			S_DONE: begin
				if (result.ready) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: store ports, compare unit control, handshakes.
	always_comb begin
		we             = 1'b0;
		waddr          = fp_q;
		wdata          = wf_q;
		raddr          = fp_q;
		mctl.clear     = accept;
		mctl.valid     = (state_q == S_SCAN) && rd_vld_s1;
		mctl.pair_mode = is_pair;
		mctl.rewrite   = is_rewrite;
		item.ready     = (state_q == S_IDLE);
		result.valid   = (state_q == S_DONE);
		unique case (state_q)
			S_PUSH: begin
				we    = 1'b1;
				waddr = is_front ? fp_dec : slot_of(fp_q, count_q[AW-1:0]);
			end
			S_POP_RD: raddr = is_front ? fp_q : slot_of(fp_q, last_pos);
			S_SCAN:   raddr = slot_of(fp_q, rd_pos_q[AW-1:0]);
			S_WR1: begin
				we    = 1'b1;
				waddr = slot_of(fp_q, hit_pos_q);
			end
			S_WR2: begin
				we    = 1'b1;
				waddr = slot_of(fp_q, hit_pos_q + 1'b1);
				wdata = ws_q;
			end
			S_FIN_F:  raddr = fp_q;
			S_FIN_B:  raddr = slot_of(fp_q, last_pos);
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			fp_q      <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (state_q == S_PUSH) begin
				count_q <= count_q + 1'b1;
				if (is_front) begin
					fp_q <= fp_dec;
				end
			end
			if (state_q == S_POP_WT) begin
				count_q <= count_q - 1'b1;
				if (is_front) begin
					fp_q <= fp_inc;
				end
			end
		end
	end

	// Held action word, scan position and result fields.
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= action_t'(item.action);
			mf_q     <= item.match_first;
			ms_q     <= item.match_second;
			wf_q     <= item.write_first;
			ws_q     <= item.write_second;
			inst_q   <= item.instance_req;
			rd_pos_q <= '0;
			popped_q <= '0;
			unique case (action_t'(item.action))
				ACT_PUSH_BACK, ACT_PUSH_FRONT: status_q <= full ? STAT_FULL : STAT_OK;
				ACT_POP_BACK, ACT_POP_FRONT:   status_q <= empty ? STAT_EMPTY : STAT_OK;
				default:                       status_q <= STAT_OK;
			endcase
		end
		if (issue) begin
			rd_pos_q <= rd_pos_q + 1'b1;
		end
		data_pos_s1 <= rd_pos_q[AW-1:0];
		if (state_q == S_SCAN) begin
			if (hit) begin
				hit_pos_q <= is_pair ? data_pos_s1 - 1'b1 : data_pos_s1;
			end else if (scan_done && is_rewrite) begin
				status_q <= STAT_MISSING;
			end
		end
		if (state_q == S_POP_WT) begin
			popped_q <= rdata;
		end
		if (state_q == S_FIN_B) begin
			front_q <= rdata;
		end
		if (state_q == S_FIN_W) begin
			back_q <= rdata;
		end
	end

	dssu_store #(
		.DEPTH     (DEPTH),
		.CODE_BITS (CODE_BITS)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr   (raddr),
		.rdata_q (rdata)
	);

	dssu_match #(
		.DEPTH     (DEPTH),
		.CODE_BITS (CODE_BITS)
	) u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (mctl),
		.code        (rdata),
		.first       (mf_q),
		.second      (ms_q),
		.target      (inst_q),
		.match_count (mcount),
		.hit         (hit)
	);

	// Result word.
	always_comb begin
		result.popped_code = popped_q;
		result.match_count = ((act_q == ACT_COUNT) || (act_q == ACT_PAIR_COUNT)) ? mcount : '0;
		result.fill_level  = count_q;
		result.front_code  = empty ? '0 : front_q;
		result.back_code   = empty ? '0 : back_q;
		result.status      = status_q;
	end

	`DSSU_ASSERT_ALWAYS(a_count_bound, count_q <= DEPTH_W)
	`DSSU_ASSERT_ALWAYS(a_scan_bound, rd_pos_q <= count_q || state_q != S_SCAN)
	`DSSU_ASSERT_ALWAYS(a_one_side, !(item.ready && result.valid))
	`DSSU_ASSERT_NEXT(a_busy_after_accept, item.valid && item.ready, !item.ready)
	`DSSU_ASSERT_NEXT(a_pop_shrinks, state_q == S_POP_WT, count_q == $past(count_q) - 1'b1)

endmodule
